[hw/rtl/fgkt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fgkt_pkg;

  localparam int unsigned DATA_W = 32;
  // Widest exact sum: state plus two rounded gain terms
  localparam int unsigned ACC_W  = 46;
  // Rounded gain term: Q28.36 product shifted down to Q28.16
  localparam int unsigned TERM_W = 44;
  // Rounded predict step: Q17.48 product shifted down to Q17.16
  localparam int unsigned STEP_W = 33;
  localparam int unsigned GAIN_FRAC = 20;
  localparam int unsigned DT_FRAC   = 32;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TIME_STEP         = 3'd0,
    REG_GAIN_POS_FROM_POS = 3'd1,
    REG_GAIN_POS_FROM_VEL = 3'd2,
    REG_GAIN_VEL_FROM_POS = 3'd3,
    REG_GAIN_VEL_FROM_VEL = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    ACT_PREDICT = 1'b0,
    ACT_UPDATE  = 1'b1
  } action_e;

  localparam logic [DATA_W-1:0]        TIME_STEP_RST         = 32'd4294967;
  localparam logic signed [DATA_W-1:0] GAIN_POS_FROM_POS_RST = 32'sd655360;
  localparam logic signed [DATA_W-1:0] GAIN_POS_FROM_VEL_RST = -32'sd786434097;
  localparam logic signed [DATA_W-1:0] GAIN_VEL_FROM_POS_RST = 32'sd459;
  localparam logic signed [DATA_W-1:0] GAIN_VEL_FROM_VEL_RST = 32'sd1966080;

  typedef struct packed {
    logic [DATA_W-1:0]        time_step;
    logic signed [DATA_W-1:0] gain_pos_from_pos;
    logic signed [DATA_W-1:0] gain_pos_from_vel;
    logic signed [DATA_W-1:0] gain_vel_from_pos;
    logic signed [DATA_W-1:0] gain_vel_from_vel;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] prev_x;
    logic signed [DATA_W-1:0] prev_y;
  } state_t;

  typedef struct packed {
    action_e                  action;
    logic signed [DATA_W-1:0] meas_x;
    logic signed [DATA_W-1:0] meas_y;
  } item_t;

  // Clamp to the 32-bit signed range
  function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] max_v;
    logic signed [ACC_W-1:0] min_v;
    max_v = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
    min_v = -max_v - ACC_W'(1);
    if (v > max_v) begin
      return max_v[DATA_W-1:0];
    end else if (v < min_v) begin
      return min_v[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  // gain * innovation, rounded to nearest with ties toward plus infinity
  function automatic logic signed [TERM_W-1:0] gain_term(
    input logic signed [DATA_W-1:0] gain,
    input logic signed [DATA_W-1:0] inn
  );
    logic signed [2*DATA_W-1:0] prod;
    logic signed [2*DATA_W-1:0] rnd;
    prod = gain * inn;
    rnd  = prod + ((2*DATA_W)'(1) <<< (GAIN_FRAC - 1));
    return rnd[2*DATA_W-1:GAIN_FRAC];
  endfunction

  // dt * velocity, rounded to nearest with ties toward plus infinity
  function automatic logic signed [STEP_W-1:0] dt_term(
    input logic [DATA_W-1:0]        dt,
    input logic signed [DATA_W-1:0] vel
  );
    logic signed [2*DATA_W:0] prod;
    logic signed [2*DATA_W:0] rnd;
    prod = $signed({1'b0, dt}) * vel;
    rnd  = prod + ((2*DATA_W+1)'(1) <<< (DT_FRAC - 1));
    return rnd[2*DATA_W:DT_FRAC];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/fgkt_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fgkt_in_if;
  import fgkt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [DATA_W-1:0] meas_x;
  logic signed [DATA_W-1:0] meas_y;

  modport source (output valid, action, meas_x, meas_y, input ready);
  modport sink   (input valid, action, meas_x, meas_y, output ready);
endinterface

interface fgkt_out_if;
  import fgkt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] est_x;
  logic signed [DATA_W-1:0] est_y;
  logic signed [DATA_W-1:0] est_vx;
  logic signed [DATA_W-1:0] est_vy;

  modport source (output valid, est_x, est_y, est_vx, est_vy, input ready);
  modport sink   (input valid, est_x, est_y, est_vx, est_vy, output ready);
endinterface

interface fgkt_cfg_if;
  import fgkt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/fixed_gain_kalman_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted word waits in the input register; when it steps, its estimate is registered.
// Throughput: one word per cycle while the sink takes results; the step logic is combinational.
// Reset (rst_ni low, asynchronous): position, velocity and last measurement clear to zero,
// the gain and time-step registers take their defaults, and both channels go empty.

module fixed_gain_kalman_tracker import fgkt_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fgkt_cfg_if.sink   cfg_i,
  fgkt_in_if.sink    in_i,
  fgkt_out_if.source out_o
);

  cfg_t   cfg;
  state_t state_d, state_q;
  item_t  item_q;
  logic   in_valid_d, in_valid_q;
  logic   out_valid_d, out_valid_q;
  logic   in_take;
  logic   step_fire;

  // Configuration register file
  fgkt_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Predict/update math on the held word and the current state
  fgkt_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (item_q),
    .state_o (state_d)
  );

  // Advance the held word whenever the result register is free or draining
  // this cycle. The input register refills in the same cycle, so a steady
  // stream moves one word per clock while the sink keeps taking results.
  assign step_fire  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step_fire;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step_fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step_fire) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (step_fire) begin
        state_q <= state_d;
      end
    end
  end

  // Capture the incoming word; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action <= action_e'(in_i.action);
      item_q.meas_x <= in_i.meas_x;
      item_q.meas_y <= in_i.meas_y;
    end
  end

  // Result register: hold the estimate until the sink takes it
  logic signed [DATA_W-1:0] est_x_q, est_y_q, est_vx_q, est_vy_q;

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      est_x_q  <= state_d.pos_x;
      est_y_q  <= state_d.pos_y;
      est_vx_q <= state_d.vel_x;
      est_vy_q <= state_d.vel_y;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.est_x  = est_x_q;
  assign out_o.est_y  = est_y_q;
  assign out_o.est_vx = est_vx_q;
  assign out_o.est_vy = est_vy_q;

endmodule

`default_nettype wire

[hw/rtl/fgkt_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module fgkt_cfg_regs import fgkt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fgkt_cfg_if.sink  cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_d, cfg_q;
  logic wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid && cfg_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_TIME_STEP:         cfg_d.time_step         = cfg_i.data;
        REG_GAIN_POS_FROM_POS: cfg_d.gain_pos_from_pos = $signed(cfg_i.data);
        REG_GAIN_POS_FROM_VEL: cfg_d.gain_pos_from_vel = $signed(cfg_i.data);
        REG_GAIN_VEL_FROM_POS: cfg_d.gain_vel_from_pos = $signed(cfg_i.data);
        REG_GAIN_VEL_FROM_VEL: cfg_d.gain_vel_from_vel = $signed(cfg_i.data);
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.time_step         <= TIME_STEP_RST;
      cfg_q.gain_pos_from_pos <= GAIN_POS_FROM_POS_RST;
      cfg_q.gain_pos_from_vel <= GAIN_POS_FROM_VEL_RST;
      cfg_q.gain_vel_from_pos <= GAIN_VEL_FROM_POS_RST;
      cfg_q.gain_vel_from_vel <= GAIN_VEL_FROM_VEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hw/rtl/fgkt_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module fgkt_step import fgkt_pkg::*; (
  input  cfg_t   cfg_i,
  input  state_t state_i,
  input  item_t  item_i,
  output state_t state_o
);

  logic signed [DATA_W-1:0] inn_px, inn_py, inn_vx, inn_vy;
  logic signed [ACC_W-1:0]  sum_px, sum_py, sum_vx, sum_vy;
  logic signed [ACC_W-1:0]  adv_x, adv_y;

  // Innovations against the state before the step, each clamped to 32 bits
  assign inn_px = sat_s32(ACC_W'(item_i.meas_x) - ACC_W'(state_i.pos_x));
  assign inn_py = sat_s32(ACC_W'(item_i.meas_y) - ACC_W'(state_i.pos_y));
  assign inn_vx = sat_s32(ACC_W'(item_i.meas_x) - ACC_W'(state_i.prev_x)
                          - ACC_W'(state_i.vel_x));
  assign inn_vy = sat_s32(ACC_W'(item_i.meas_y) - ACC_W'(state_i.prev_y)
                          - ACC_W'(state_i.vel_y));

  assign sum_px = ACC_W'(state_i.pos_x)
                + ACC_W'(gain_term(cfg_i.gain_pos_from_pos, inn_px))
                + ACC_W'(gain_term(cfg_i.gain_pos_from_vel, inn_vx));
  assign sum_py = ACC_W'(state_i.pos_y)
                + ACC_W'(gain_term(cfg_i.gain_pos_from_pos, inn_py))
                + ACC_W'(gain_term(cfg_i.gain_pos_from_vel, inn_vy));
  assign sum_vx = ACC_W'(state_i.vel_x)
                + ACC_W'(gain_term(cfg_i.gain_vel_from_pos, inn_px))
                + ACC_W'(gain_term(cfg_i.gain_vel_from_vel, inn_vx));
  assign sum_vy = ACC_W'(state_i.vel_y)
                + ACC_W'(gain_term(cfg_i.gain_vel_from_pos, inn_py))
                + ACC_W'(gain_term(cfg_i.gain_vel_from_vel, inn_vy));

  assign adv_x = ACC_W'(state_i.pos_x) + ACC_W'(dt_term(cfg_i.time_step, state_i.vel_x));
  assign adv_y = ACC_W'(state_i.pos_y) + ACC_W'(dt_term(cfg_i.time_step, state_i.vel_y));

  always_comb begin
    state_o = state_i;
    if (item_i.action == ACT_UPDATE) begin
      state_o.pos_x  = sat_s32(sum_px);
      state_o.pos_y  = sat_s32(sum_py);
      state_o.vel_x  = sat_s32(sum_vx);
      state_o.vel_y  = sat_s32(sum_vy);
      state_o.prev_x = item_i.meas_x;
      state_o.prev_y = item_i.meas_y;
    end else begin
      state_o.pos_x  = sat_s32(adv_x);
      state_o.pos_y  = sat_s32(adv_y);
    end
  end

endmodule

`default_nettype wire
